### hdl/cbs_pkg.sv
package cbs_pkg;

    localparam int COL_W      = 24;
    localparam int WIDTH_W    = COL_W + 1;
    localparam int PROC_W     = 12;
    localparam int CAND_W     = PROC_W + 1;
    localparam int RATIO_W    = 13;
    localparam int FACTOR_W   = 8;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int DIV_CNT_W  = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COLS_2D  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLS_2D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COLS_1D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLS_1D  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_FACTOR = 3'd5;

    // configuration reset values
    localparam logic [RATIO_W-1:0]  RST_RATIO_LIMIT  = 13'd4;
    localparam logic [COL_W-1:0]    RST_MIN_COLS     = 24'd60;
    localparam logic [COL_W-1:0]    RST_MAX_COLS     = 24'd120;
    localparam logic [FACTOR_W-1:0] RST_ADAPT_FACTOR = 8'd4;

    localparam logic [CNT_W-1:0] MIN_SPLIT = 7'd4;

    typedef struct packed {
        logic [COL_W-1:0]  first_col;
        logic [COL_W-1:0]  last_col;
        logic [PROC_W-1:0] first_proc;
        logic [PROC_W-1:0] last_proc;
        logic              final_block;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0] piece_first;
        logic [COL_W-1:0] piece_last;
        logic [CNT_W-1:0] piece_count;
        logic [COL_W-1:0] first_piece_index;
        logic [COL_W-1:0] added_total;
        logic             last_piece;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_POST,
        S_CAP,
        S_EMIT,
        S_FINISH
    } t_state;

    // what the running division is for
    typedef enum logic [1:0] {
        PH_STEP_SIZE,
        PH_COUNT,
        PH_CHECK,
        PH_PIECE_W
    } t_phase;

endpackage

### hdl/column_block_splitter_unit.sv
// column block splitter
//
// input channel: one request per column block (first/last column, first/last
// candidate processor, final-block flag) on i_in_valid / o_in_stall. the block
// takes one request at a time and holds o_in_stall high until the request is
// fully handled, all of its pieces included.
// output channel: one request per piece on o_out_valid / i_out_stall, held in
// an output register; a new block can be taken while the last piece waits.
// config port: i_cfg_we / i_cfg_index / i_cfg_data, written while idle.
//
// planning: every piece count and piece width comes from one shared radix-2
// restoring divider, followed by a post step that uses the quotient. a split
// block needs three divisions (one candidate or zero factor) or four, then
// one piece per cycle while the receiver keeps up, then a closing state. a
// block that is not split closes after setup, up to three divisions, the
// count check and the closing state.
// reset (synchronous, active low) loads the register defaults 4, 60, 120,
// 60, 120, 4 and clears the piece and added-block counters. a stall on the
// output simply holds the current piece and pauses emission.
module column_block_splitter_unit #(
    parameter int MAX_PIECES = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cbs_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cbs_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_we,
    input  logic [cbs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int COL_W   = cbs_pkg::COL_W;
    localparam int WIDTH_W = cbs_pkg::WIDTH_W;
    localparam int CNT_W   = cbs_pkg::CNT_W;
    localparam int DCNT_W  = cbs_pkg::DIV_CNT_W;

    // configuration registers
    logic [cbs_pkg::RATIO_W-1:0]  r_ratio_limit;
    logic [COL_W-1:0]             r_min_2d, r_max_2d, r_min_1d, r_max_1d;
    logic [cbs_pkg::FACTOR_W-1:0] r_factor;

    // control state
    cbs_pkg::t_state r_state, n_state;
    cbs_pkg::t_phase r_phase, n_phase;
    logic [DCNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [COL_W-1:0]  r_piece_index, n_piece_index;
    logic [COL_W-1:0]  r_added, n_added;
    logic              r_out_valid, n_out_valid;
    logic [CNT_W-1:0]  r_idx, n_idx;

    // per-block working registers
    logic [COL_W-1:0]              r_fc, n_fc;
    logic [COL_W-1:0]              r_lc, n_lc;
    logic                          r_fin, n_fin;
    logic                          r_ok, n_ok;
    logic [WIDTH_W-1:0]            r_width, n_width;
    logic [cbs_pkg::CAND_W-1:0]    r_cand, n_cand;
    logic                          r_wide, n_wide;
    logic [WIDTH_W-1:0]            r_n, n_n;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [COL_W-1:0]              r_step, n_step;
    logic [COL_W-1:0]              r_cur, n_cur;
    logic [COL_W-1:0]              r_first_idx, n_first_idx;

    // shared divider
    logic [WIDTH_W-1:0] r_rem, n_rem;
    logic [WIDTH_W-1:0] r_quo, n_quo;
    logic [WIDTH_W-1:0] r_divisor, n_divisor;

    cbs_pkg::t_out_item r_out, n_out;

    // combinational helpers
    logic [COL_W-1:0]   lo, hi;
    logic [8:0]         f_eff;
    logic [21:0]        f_cand;
    logic [WIDTH_W:0]   div_trial;
    logic [WIDTH_W:0]   div_diff;
    logic               div_ge;
    logic [WIDTH_W-1:0] s_clamp;
    logic [WIDTH_W-1:0] n_capped;
    logic               out_free;
    logic               is_last;

    assign o_in_stall  = (r_state != cbs_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // bounds of the current block, zero register reads as one
    always_comb begin
        lo = r_wide ? r_min_2d : r_min_1d;
        hi = r_wide ? r_max_2d : r_max_1d;
        if (lo == '0) begin
            lo = COL_W'(1);
        end
        if (hi == '0) begin
            hi = COL_W'(1);
        end
    end

    assign f_eff  = r_wide ? {r_factor, 1'b0} : {1'b0, r_factor};
    assign f_cand = 22'(f_eff) * 22'(r_cand);

    // one restoring step
    assign div_trial = {r_rem, r_quo[WIDTH_W-1]};
    assign div_ge    = div_trial >= {1'b0, r_divisor};
    assign div_diff  = div_trial - {1'b0, r_divisor};

    // clamp: minimum first, then maximum
    always_comb begin
        s_clamp = r_quo;
        if (s_clamp < WIDTH_W'(lo)) begin
            s_clamp = WIDTH_W'(lo);
        end
        if (s_clamp > WIDTH_W'(hi)) begin
            s_clamp = WIDTH_W'(hi);
        end
    end

    assign n_capped = (r_n > WIDTH_W'(MAX_PIECES)) ? WIDTH_W'(MAX_PIECES) : r_n;
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_last  = (r_idx == r_count - CNT_W'(1));

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_div_cnt     = r_div_cnt;
        n_piece_index = r_piece_index;
        n_added       = r_added;
        n_out_valid   = r_out_valid && i_out_stall;
        n_idx         = r_idx;
        n_fc          = r_fc;
        n_lc          = r_lc;
        n_fin         = r_fin;
        n_ok          = r_ok;
        n_width       = r_width;
        n_cand        = r_cand;
        n_wide        = r_wide;
        n_n           = r_n;
        n_count       = r_count;
        n_step        = r_step;
        n_cur         = r_cur;
        n_first_idx   = r_first_idx;
        n_rem         = r_rem;
        n_quo         = r_quo;
        n_divisor     = r_divisor;
        n_out         = r_out;

        unique case (r_state)
            cbs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_fc    = i_in_data.first_col;
                    n_lc    = i_in_data.last_col;
                    n_fin   = i_in_data.final_block;
                    n_ok    = (i_in_data.last_col >= i_in_data.first_col) &&
                              (i_in_data.last_proc >= i_in_data.first_proc);
                    n_width = WIDTH_W'(i_in_data.last_col) -
                              WIDTH_W'(i_in_data.first_col) + WIDTH_W'(1);
                    n_cand  = cbs_pkg::CAND_W'(i_in_data.last_proc) -
                              cbs_pkg::CAND_W'(i_in_data.first_proc) +
                              cbs_pkg::CAND_W'(1);
                    n_wide  = n_cand > r_ratio_limit;
                    n_state = cbs_pkg::S_SETUP;
                end
            end
            cbs_pkg::S_SETUP: begin
                n_rem     = '0;
                n_div_cnt = DCNT_W'(WIDTH_W - 1);
                n_quo     = r_width;
                n_state   = cbs_pkg::S_DIV;
                if (!r_ok) begin
                    n_state = cbs_pkg::S_FINISH;
                end else if (r_cand == cbs_pkg::CAND_W'(1)) begin
                    // single candidate: split only above the maximum of the current bounds
                    n_divisor = WIDTH_W'(hi);
                    n_phase   = cbs_pkg::PH_COUNT;
                    if (r_width <= WIDTH_W'(hi)) begin
                        n_state = cbs_pkg::S_FINISH;
                    end
                end else if (f_eff != '0) begin
                    n_divisor = WIDTH_W'(f_cand);
                    n_phase   = cbs_pkg::PH_STEP_SIZE;
                end else begin
                    // ceiling divide by the minimum width
                    n_quo     = r_width + WIDTH_W'(lo) - WIDTH_W'(1);
                    n_divisor = WIDTH_W'(lo);
                    n_phase   = cbs_pkg::PH_COUNT;
                end
            end
            cbs_pkg::S_DIV: begin
                if (div_ge) begin
                    n_rem = div_diff[WIDTH_W-1:0];
                end else begin
                    n_rem = div_trial[WIDTH_W-1:0];
                end
                n_quo = {r_quo[WIDTH_W-2:0], div_ge};
                if (r_div_cnt == '0) begin
                    n_state = cbs_pkg::S_POST;
                end else begin
                    n_div_cnt = r_div_cnt - DCNT_W'(1);
                end
            end
            cbs_pkg::S_POST: begin
                n_rem     = '0;
                n_div_cnt = DCNT_W'(WIDTH_W - 1);
                unique case (r_phase)
                    cbs_pkg::PH_STEP_SIZE: begin
                        n_quo     = r_width;
                        n_divisor = s_clamp;
                        n_phase   = cbs_pkg::PH_COUNT;
                        n_state   = cbs_pkg::S_DIV;
                    end
                    cbs_pkg::PH_COUNT: begin
                        n_n = r_quo;
                        if (r_quo > WIDTH_W'(1)) begin
                            n_quo     = r_width;
                            n_divisor = r_quo;
                            n_phase   = cbs_pkg::PH_CHECK;
                            n_state   = cbs_pkg::S_DIV;
                        end else begin
                            n_state = cbs_pkg::S_CAP;
                        end
                    end
                    cbs_pkg::PH_CHECK: begin
                        // pieces narrower than the minimum: one fewer
                        if (r_quo < WIDTH_W'(lo)) begin
                            n_n = r_n - WIDTH_W'(1);
                        end
                        n_state = cbs_pkg::S_CAP;
                    end
                    cbs_pkg::PH_PIECE_W: begin
                        n_step        = r_quo[COL_W-1:0];
                        n_first_idx   = r_piece_index;
                        n_added       = r_added + COL_W'(r_count) - COL_W'(1);
                        n_piece_index = r_piece_index + COL_W'(r_count);
                        n_cur         = r_fc;
                        n_idx         = '0;
                        n_state       = cbs_pkg::S_EMIT;
                    end
                    default: begin
                        n_state = cbs_pkg::S_FINISH;
                    end
                endcase
            end
            cbs_pkg::S_CAP: begin
                if (n_capped < WIDTH_W'(cbs_pkg::MIN_SPLIT)) begin
                    n_state = cbs_pkg::S_FINISH;
                end else begin
                    n_count   = n_capped[CNT_W-1:0];
                    n_rem     = '0;
                    n_quo     = r_width;
                    n_divisor = n_capped;
                    n_div_cnt = DCNT_W'(WIDTH_W - 1);
                    n_phase   = cbs_pkg::PH_PIECE_W;
                    n_state   = cbs_pkg::S_DIV;
                end
            end
            cbs_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out.piece_first       = r_cur;
                    n_out.piece_last        = is_last ? r_lc : (r_cur + r_step - COL_W'(1));
                    n_out.piece_count       = r_count;
                    n_out.first_piece_index = r_first_idx;
                    n_out.added_total       = r_added;
                    n_out.last_piece        = is_last;
                    n_out_valid             = 1'b1;
                    n_cur                   = r_cur + r_step;
                    n_idx                   = r_idx + CNT_W'(1);
                    if (is_last) begin
                        n_state = cbs_pkg::S_FINISH;
                    end
                end
            end
            cbs_pkg::S_FINISH: begin
                if (r_fin) begin
                    n_piece_index = '0;
                    n_added       = '0;
                end
                n_state = cbs_pkg::S_IDLE;
            end
            default: begin
                n_state = cbs_pkg::S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= cbs_pkg::PH_COUNT;
            r_div_cnt     <= '0;
            r_piece_index <= '0;
            r_added       <= '0;
            r_out_valid   <= 1'b0;
            r_idx         <= '0;
            r_ratio_limit <= cbs_pkg::RST_RATIO_LIMIT;
            r_min_2d      <= cbs_pkg::RST_MIN_COLS;
            r_max_2d      <= cbs_pkg::RST_MAX_COLS;
            r_min_1d      <= cbs_pkg::RST_MIN_COLS;
            r_max_1d      <= cbs_pkg::RST_MAX_COLS;
            r_factor      <= cbs_pkg::RST_ADAPT_FACTOR;
        end else begin
            r_phase       <= n_phase;
            r_div_cnt     <= n_div_cnt;
            r_piece_index <= n_piece_index;
            r_added       <= n_added;
            r_out_valid   <= n_out_valid;
            r_idx         <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cbs_pkg::CFG_RATIO_LIMIT:  r_ratio_limit <= i_cfg_data[cbs_pkg::RATIO_W-1:0];
                    cbs_pkg::CFG_MIN_COLS_2D:  r_min_2d      <= i_cfg_data[COL_W-1:0];
                    cbs_pkg::CFG_MAX_COLS_2D:  r_max_2d      <= i_cfg_data[COL_W-1:0];
                    cbs_pkg::CFG_MIN_COLS_1D:  r_min_1d      <= i_cfg_data[COL_W-1:0];
                    cbs_pkg::CFG_MAX_COLS_1D:  r_max_1d      <= i_cfg_data[COL_W-1:0];
                    cbs_pkg::CFG_ADAPT_FACTOR: r_factor      <= i_cfg_data[cbs_pkg::FACTOR_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        r_fc        <= n_fc;
        r_lc        <= n_lc;
        r_fin       <= n_fin;
        r_ok        <= n_ok;
        r_width     <= n_width;
        r_cand      <= n_cand;
        r_wide      <= n_wide;
        r_n         <= n_n;
        r_count     <= n_count;
        r_step      <= n_step;
        r_cur       <= n_cur;
        r_first_idx <= n_first_idx;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_divisor   <= n_divisor;
        r_out       <= n_out;
    end

endmodule

### hdl/cbs_checker.sv
module cbs_checker #(
    parameter int MAX_PIECES = 64
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input cbs_pkg::t_out_item             o_out_data
);

    // a taken block always needs planning cycles
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block ready right after taking a request");

    // pieces never run backward
    a_piece_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.piece_first <= o_out_data.piece_last))
        else $error("piece first column beyond its last column");

    // piece count within the split range
    a_piece_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.piece_count >= cbs_pkg::MIN_SPLIT &&
                         o_out_data.piece_count <= cbs_pkg::CNT_W'(MAX_PIECES)))
        else $error("piece count out of range");

    // stalled piece holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled piece changed");

endmodule

bind column_block_splitter_unit cbs_checker #(.MAX_PIECES(MAX_PIECES)) u_cbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### sim/tb_column_block_splitter_unit.sv
`timescale 1ns / 100ps

module tb_column_block_splitter_unit;

    import cbs_pkg::*;

    localparam int MAX_PIECES     = 64;
    // planning takes up to four divisions
    localparam int SETTLE_CYCLES  = 200;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    // block request side
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    in_data = '0;

    // piece request side
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_out_item   o_out_data;

    // register port
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RATIO_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // shadow copy of the registers, matching the reset defaults
    logic [RATIO_W-1:0]  cfg_ratio  = RST_RATIO_LIMIT;
    logic [COL_W-1:0]    cfg_min_2d = RST_MIN_COLS;
    logic [COL_W-1:0]    cfg_max_2d = RST_MAX_COLS;
    logic [COL_W-1:0]    cfg_min_1d = RST_MIN_COLS;
    logic [COL_W-1:0]    cfg_max_1d = RST_MAX_COLS;
    logic [FACTOR_W-1:0] cfg_factor = RST_ADAPT_FACTOR;

    // running piece index and added-block count, as the block keeps them
    logic [COL_W-1:0] run_index = '0;
    logic [COL_W-1:0] run_added = '0;

    // pieces predicted but not yet seen on the output
    t_out_item pending_pieces[$];
    t_out_item want_piece;

    int  fails = 0;
    int  quiet_cycles = 0;
    int  stall_left = 0;
    bit  idle_en = 1'b1;

    column_block_splitter_unit #(
        .MAX_PIECES(MAX_PIECES)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // a zero width bound behaves as one column
    function automatic longint unsigned nonzero(input longint unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // number of pieces before the cap, from the current bounds
    function automatic longint unsigned plan_pieces(input longint unsigned cand,
                                                    input longint unsigned width);
        longint unsigned lo, hi, f, s, n;
        bit wide;
        wide = (cand > cfg_ratio);
        lo = nonzero(wide ? cfg_min_2d : cfg_min_1d);
        hi = nonzero(wide ? cfg_max_2d : cfg_max_1d);
        if (cand == 1) begin
            // single candidate: split only when wider than the max
            if (width <= hi) return 1;
            n = width / hi;
        end else begin
            f = wide ? 2 * longint'(cfg_factor) : longint'(cfg_factor);
            if (f > 0) begin
                // adaptive step, min applied first so a crossed max wins
                s = width / (f * cand);
                if (s < lo) s = lo;
                if (s > hi) s = hi;
                n = width / s;
            end else begin
                n = (width + lo - 1) / lo;
            end
        end
        if (n > 1 && (width / n) < lo) n--;
        return n;
    endfunction

    // predict the pieces of one accepted block and advance the counters
    task automatic split_block(input t_in_item blk);
        longint unsigned fc, lc, width, cand, n, piece_w, i;
        t_out_item piece;
        fc = blk.first_col;
        lc = blk.last_col;
        if (lc >= fc && blk.last_proc >= blk.first_proc) begin
            width = lc - fc + 1;
            cand = longint'(blk.last_proc) - longint'(blk.first_proc) + 1;
            n = plan_pieces(cand, width);
            if (n > MAX_PIECES) n = MAX_PIECES;
            if (n >= MIN_SPLIT) begin
                piece_w = width / n;
                piece.first_piece_index = run_index;
                run_added = run_added + n - 1;
                run_index = run_index + n;
                for (i = 0; i < n; i++) begin
                    piece.piece_first = fc + piece_w * i;
                    piece.piece_last = (i + 1 == n) ? lc : fc + piece_w * (i + 1) - 1;
                    piece.piece_count = n;
                    piece.added_total = run_added;
                    piece.last_piece = (i + 1 == n);
                    pending_pieces.push_back(piece);
                end
            end
        end
        // counters clear after a final block, split or not
        if (blk.final_block) begin
            run_index = '0;
            run_added = '0;
        end
    endtask

    function automatic t_in_item col_block(input logic [COL_W-1:0] fc,
                                           input logic [COL_W-1:0] lc,
                                           input logic [PROC_W-1:0] fp,
                                           input logic [PROC_W-1:0] lp,
                                           input logic fin);
        t_in_item blk;
        blk.first_col = fc;
        blk.last_col = lc;
        blk.first_proc = fp;
        blk.last_proc = lp;
        blk.final_block = fin;
        return blk;
    endfunction

    // mostly well-formed blocks sized to the current bounds, some noise
    function automatic t_in_item random_block();
        t_in_item blk;
        longint unsigned cand, width, span, lo, hi, lo_c, hi_c, fc;
        int unsigned kind;
        bit wide;
        blk = '0;
        kind = $urandom_range(0, 19);
        if (kind < 16) begin
            case ($urandom_range(0, 9))
                0, 1: cand = 1;
                2, 3, 4, 5: begin
                    hi_c = (cfg_ratio > 4096) ? 4096 : cfg_ratio;
                    cand = $urandom_range(2, (hi_c > 2) ? hi_c : 2);
                end
                default: begin
                    lo_c = (cfg_ratio >= 4096) ? 4096 : cfg_ratio + 1;
                    hi_c = lo_c + (($urandom_range(0, 3) == 0) ? 4096 : 48);
                    if (hi_c > 4096) hi_c = 4096;
                    cand = $urandom_range(lo_c, hi_c);
                end
            endcase
            wide = (cand > cfg_ratio);
            lo = nonzero(wide ? cfg_min_2d : cfg_min_1d);
            hi = nonzero(wide ? cfg_max_2d : cfg_max_1d);
            span = ((lo > hi) ? lo : hi) * 72;
            if (span > 64'd16777216) span = 64'd16777216;
            width = $urandom_range(1, span);
            fc = $urandom_range(0, 64'd16777216 - width);
            blk.first_col = fc;
            blk.last_col = fc + width - 1;
            blk.first_proc = $urandom_range(0, 4096 - cand);
            blk.last_proc = blk.first_proc + cand - 1;
        end else if (kind < 18) begin
            // anywhere in the column and processor space
            blk.first_col = $urandom;
            blk.last_col = $urandom_range(blk.first_col, 24'hFFFFFF);
            blk.first_proc = $urandom;
            blk.last_proc = $urandom_range(blk.first_proc, 12'hFFF);
        end else if (kind == 18) begin
            // reversed columns
            blk.first_col = $urandom_range(1, 24'hFFFFFF);
            blk.last_col = $urandom_range(0, blk.first_col - 1);
            blk.first_proc = $urandom;
            blk.last_proc = $urandom_range(blk.first_proc, 12'hFFF);
        end else begin
            // reversed candidates
            blk.first_col = $urandom;
            blk.last_col = $urandom;
            blk.first_proc = $urandom_range(1, 12'hFFF);
            blk.last_proc = $urandom_range(0, blk.first_proc - 1);
        end
        blk.final_block = ($urandom_range(0, 11) == 0);
        return blk;
    endfunction

    // one block request; valid stays up until the block takes it
    task automatic send_block(input t_in_item blk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= blk;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        split_block(blk);
    endtask

    // wait until every piece is out and any unsplit block has finished
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pieces.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_RATIO_LIMIT:  cfg_ratio = value[RATIO_W-1:0];
            CFG_MIN_COLS_2D:  cfg_min_2d = value;
            CFG_MAX_COLS_2D:  cfg_max_2d = value;
            CFG_MIN_COLS_1D:  cfg_min_1d = value;
            CFG_MAX_COLS_1D:  cfg_max_1d = value;
            CFG_ADAPT_FACTOR: cfg_factor = value[FACTOR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] ratio,
                                  input logic [CFG_DATA_W-1:0] mn2,
                                  input logic [CFG_DATA_W-1:0] mx2,
                                  input logic [CFG_DATA_W-1:0] mn1,
                                  input logic [CFG_DATA_W-1:0] mx1,
                                  input logic [CFG_DATA_W-1:0] factor);
        settle();
        write_reg(CFG_RATIO_LIMIT, ratio);
        write_reg(CFG_MIN_COLS_2D, mn2);
        write_reg(CFG_MAX_COLS_2D, mx2);
        write_reg(CFG_MIN_COLS_1D, mn1);
        write_reg(CFG_MAX_COLS_1D, mx1);
        write_reg(CFG_ADAPT_FACTOR, factor);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_bound();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 24'hFFFFFF;
            2: return $urandom;
            default: return $urandom_range(1, 250);
        endcase
    endfunction

    // reset defaults: 1D and 2D splits, the cap, the counters, rejected blocks
    task automatic test_default_bounds();
        send_block(col_block(24'd0, 24'd599, 12'd7, 12'd7, 1'b0));
        send_block(col_block(24'd1000, 24'd1479, 12'd0, 12'd0, 1'b0));
        // one candidate, three pieces only: nothing out
        send_block(col_block(24'd1000, 24'd1478, 12'd0, 12'd0, 1'b0));
        send_block(col_block(24'd50, 24'd169, 12'd3, 12'd3, 1'b0));
        send_block(col_block(24'd0, 24'd999, 12'd10, 12'd11, 1'b0));
        send_block(col_block(24'd20, 24'd4019, 12'd0, 12'd4, 1'b0));
        // widest block, every candidate: capped at the max piece count
        send_block(col_block(24'd0, 24'hFFFFFF, 12'd0, 12'hFFF, 1'b0));
        send_block(col_block(24'hFFF000, 24'hFFFFFF, 12'd100, 12'd102, 1'b0));
        // reversed columns, then reversed candidates
        send_block(col_block(24'd100, 24'd99, 12'd1, 12'd2, 1'b0));
        send_block(col_block(24'd0, 24'd5000, 12'd10, 12'd9, 1'b0));
        send_block(col_block(24'd5, 24'd5, 12'd0, 12'd0, 1'b0));
        // final block that splits, then one that does not
        send_block(col_block(24'd300, 24'd2299, 12'd8, 12'd9, 1'b1));
        send_block(col_block(24'd0, 24'd899, 12'd8, 12'd9, 1'b0));
        send_block(col_block(24'd0, 24'd49, 12'd8, 12'd9, 1'b1));
        send_block(col_block(24'd0, 24'd699, 12'd0, 12'd0, 1'b0));
        send_block(col_block(24'd77, 24'd7076, 12'd4090, 12'hFFF, 1'b0));
    endtask

    // crossed bounds, zero bounds, zero and full factor, ratio extremes
    task automatic test_register_extremes();
        // every candidate count is 2D, min above max
        apply_settings(24'd0, 24'd200, 24'd50, 24'd0, 24'd0, 24'd5);
        send_block(col_block(24'd0, 24'd999, 12'd0, 12'd2, 1'b0));
        send_block(col_block(24'd10, 24'd509, 12'd9, 12'd9, 1'b0));
        // nothing is 2D; 1D bounds of zero act as one column
        apply_settings(24'd4096, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 24'd255);
        send_block(col_block(24'd0, 24'd39, 12'd0, 12'hFFF, 1'b0));
        send_block(col_block(24'd500, 24'd509, 12'd3, 12'd3, 1'b0));
        send_block(col_block(24'd0, 24'hFFFFFF, 12'd0, 12'd1, 1'b1));
        // ceiling divide with the count lowered by one
        apply_settings(24'd4, 24'd1, 24'hFFFFFF, 24'd100, 24'd200, 24'd0);
        send_block(col_block(24'd0, 24'd1049, 12'd0, 12'd2, 1'b0));
        send_block(col_block(24'd0, 24'd8, 12'd0, 12'd7, 1'b0));
        send_block(col_block(24'd0, 24'd99, 12'd0, 12'd0, 1'b0));
    endtask

    task automatic test_random_settings();
        int phase;
        int k;
        logic [CFG_DATA_W-1:0] ratio, factor;
        for (phase = 0; phase < 6; phase++) begin
            ratio = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4096)
                                                : $urandom_range(0, 12);
            case ($urandom_range(0, 5))
                0: factor = '0;
                1: factor = 24'd255;
                2: factor = $urandom_range(1, 255);
                default: factor = $urandom_range(1, 8);
            endcase
            apply_settings(ratio, random_bound(), random_bound(), random_bound(),
                           random_bound(), factor);
            for (k = 0; k < 60; k++) send_block(random_block());
        end
    endtask

    // no gaps and no stalls: requests back to back on both sides
    task automatic test_back_to_back();
        int k;
        idle_en = 1'b0;
        apply_settings(24'd4, 24'd20, 24'd60, 24'd20, 24'd60, 24'd2);
        for (k = 0; k < 70; k++) send_block(random_block());
    endtask

    // receiver stalls in bursts, started only while idle_en is set
    always @(posedge clk) begin
        if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // every accepted piece against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_pieces.size() == 0) begin
                $error("piece with nothing pending: piece_first expected none got %0d",
                       o_out_data.piece_first);
                fails++;
            end else begin
                want_piece = pending_pieces.pop_front();
                if (o_out_data.piece_first !== want_piece.piece_first) begin
                    $error("piece_first expected %0d got %0d",
                           want_piece.piece_first, o_out_data.piece_first);
                    fails++;
                end
                if (o_out_data.piece_last !== want_piece.piece_last) begin
                    $error("piece_last expected %0d got %0d",
                           want_piece.piece_last, o_out_data.piece_last);
                    fails++;
                end
                if (o_out_data.piece_count !== want_piece.piece_count) begin
                    $error("piece_count expected %0d got %0d",
                           want_piece.piece_count, o_out_data.piece_count);
                    fails++;
                end
                if (o_out_data.first_piece_index !== want_piece.first_piece_index) begin
                    $error("first_piece_index expected %0d got %0d",
                           want_piece.first_piece_index, o_out_data.first_piece_index);
                    fails++;
                end
                if (o_out_data.added_total !== want_piece.added_total) begin
                    $error("added_total expected %0d got %0d",
                           want_piece.added_total, o_out_data.added_total);
                    fails++;
                end
                if (o_out_data.last_piece !== want_piece.last_piece) begin
                    $error("last_piece expected %0d got %0d",
                           want_piece.last_piece, o_out_data.last_piece);
                    fails++;
                end
            end
        end
    end

    // stop if no request moves on either side for too long
    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_bounds();
        test_register_extremes();
        test_random_settings();
        test_back_to_back();
        settle();
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
